### rtl/core/rbdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbdg_pkg
// Shared constants, beat types and the 12-bit Gray decoder for the
// four-chip bit-plane deinterleaver.
// ----------------------------------------------------------------------------
package rbdg_pkg;

	localparam int unsigned NumChips = 4;

	localparam logic [1:0] FMT_LEAD   = 2'd0;
	localparam logic [1:0] FMT_PLAIN  = 2'd1;
	localparam logic [1:0] FMT_PACKED = 2'd2;
	localparam logic [1:0] FMT_NONE   = 2'd3;

	localparam logic [14:0] LEN_FMT0    = 15'd30787;
	localparam logic [14:0] LEN_FMT1    = 15'd30786;
	localparam logic [14:0] LEN_FMT2    = 15'd15394;
	localparam logic [14:0] BODY_PLAIN  = 15'd30784;
	localparam logic [14:0] BODY_PACKED = 15'd15392;

	localparam logic [10:0] IDX_GRAY_END = 11'd1920;
	localparam logic [10:0] IDX_ROLL     = 11'd1920;
	localparam logic [10:0] IDX_TS_HI    = 11'd1921;
	localparam logic [10:0] IDX_TS_LO    = 11'd1922;
	localparam logic [10:0] IDX_TRAILER  = 11'd1924;

	localparam logic [7:0] DAC_MAGIC_LO = 8'hAB;
	localparam logic [7:0] DAC_MAGIC_HI = 8'hCD;

	typedef logic [15:0] word_t;
	typedef logic [23:0] stamp_t;

	typedef struct packed {
		logic                       valid;
		logic [10:0]                index;
		word_t [NumChips-1:0]       words;
		logic [15:0]                dac;
	} beat_t;

	typedef struct packed {
		logic [10:0]                index;
		word_t [NumChips-1:0]       words;
		logic [3:0]                 roll_pos;
		logic                       roll_mismatch;
		stamp_t [NumChips-1:0]      stamps;
		logic [15:0]                dac;
	} result_t;

	function automatic logic [11:0] gray12(input logic [11:0] g);
		logic        acc;
		logic [11:0] r;
		acc = 1'b0;
		r   = '0;
		for (int b = 11; b >= 0; b--) begin
			acc  = acc ^ g[b];
			r[b] = acc;
		end
		return r;
	endfunction

endpackage

### rtl/core/rbdg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbdg_in_if
// Byte channel: one raw stream byte and its event start mark per beat.
// ----------------------------------------------------------------------------
interface rbdg_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;
	logic       event_start;

	modport source (output valid, raw_byte, event_start, input ready);
	modport sink   (input valid, raw_byte, event_start, output ready);
endinterface

### rtl/core/rbdg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbdg_out_if
// Word channel: one completed word set or trailer per beat.
// ----------------------------------------------------------------------------
interface rbdg_out_if;
	logic        valid;
	logic        ready;
	logic [10:0] word_index;
	logic [15:0] word_chip0;
	logic [15:0] word_chip1;
	logic [15:0] word_chip2;
	logic [15:0] word_chip3;
	logic [3:0]  roll_pos;
	logic        roll_mismatch;
	logic [23:0] timestamp_chip0;
	logic [23:0] timestamp_chip1;
	logic [23:0] timestamp_chip2;
	logic [23:0] timestamp_chip3;
	logic [15:0] injection_dac;

	modport source (
		output valid, word_index, word_chip0, word_chip1, word_chip2, word_chip3,
		       roll_pos, roll_mismatch, timestamp_chip0, timestamp_chip1,
		       timestamp_chip2, timestamp_chip3, injection_dac,
		input  ready
	);
	modport sink (
		input  valid, word_index, word_chip0, word_chip1, word_chip2, word_chip3,
		       roll_pos, roll_mismatch, timestamp_chip0, timestamp_chip1,
		       timestamp_chip2, timestamp_chip3, injection_dac,
		output ready
	);
endinterface

### rtl/core/rbdg_assemble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbdg_assemble
// Tracks the byte position in the event, places bit-plane bits into the
// four chip words and registers each completed word or trailer beat.
// ----------------------------------------------------------------------------
module rbdg_assemble
	import rbdg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic       adv,
	input  logic       in_valid,
	input  logic [7:0] raw_byte,
	input  logic       event_start,
	output beat_t      beat_s1
);

	logic [1:0]           fmt_q;
	logic [14:0]          pos_q;
	word_t [NumChips-1:0] asm_q;
	logic [7:0]           dac_lo_q;

	logic                 accept;
	logic                 fmt_ok;
	logic                 is_packed;
	logic [14:0]          len;
	logic                 restart;
	logic [14:0]          pos;
	logic [14:0]          pos_inc;
	logic [14:0]          pos_nxt;
	logic [14:0]          off;
	logic [14:0]          body_end;
	logic [14:0]          rel;
	logic                 in_body;
	logic                 is_dac_lo;
	logic                 is_dac_hi;
	logic [2:0]           j3;
	logic [3:0]           j4;
	logic                 first;
	logic                 last;
	logic [10:0]          idx;
	logic [3:0]           sh;
	word_t [NumChips-1:0] base;
	word_t [NumChips-1:0] nxt;
	logic [15:0]          dac;

	always_comb begin
		accept    = in_valid & adv;
		fmt_ok    = (fmt_q != FMT_NONE);
		is_packed = (fmt_q == FMT_PACKED);
		case (fmt_q)
			FMT_LEAD:  len = LEN_FMT0;
			FMT_PLAIN: len = LEN_FMT1;
			default:   len = LEN_FMT2;
		endcase
		restart  = event_start | (pos_q >= len);
		pos      = restart ? '0 : pos_q;
		pos_inc  = pos + 15'd1;
		pos_nxt  = (pos_inc >= len) ? '0 : pos_inc;
		off      = (fmt_q == FMT_LEAD) ? 15'd1 : 15'd0;
		body_end = off + (is_packed ? BODY_PACKED : BODY_PLAIN);
		rel      = pos - off;
		in_body  = (pos >= off) && (pos < body_end);
		is_dac_lo = (pos == body_end);
		is_dac_hi = (pos == body_end + 15'd1);
		j3 = rel[2:0];
		j4 = rel[3:0];
		if (is_packed) begin
			first = (j3 == 3'd0);
			last  = (j3 == 3'd7);
			idx   = rel[13:3];
			sh    = {3'd7 - j3, 1'b0};
		end else begin
			first = (j4 == 4'd0);
			last  = (j4 == 4'd15);
			idx   = rel[14:4];
			sh    = 4'd15 - j4;
		end
		for (int k = 0; k < NumChips; k++) begin
			base[k] = (restart | first) ? '0 : asm_q[k];
			if (is_packed)
				nxt[k] = base[k] | (word_t'({raw_byte[7-k], raw_byte[3-k]}) << sh);
			else
				nxt[k] = base[k] | (word_t'(raw_byte[3-k]) << sh);
		end
		if ((fmt_q == FMT_LEAD) || ((dac_lo_q == DAC_MAGIC_LO) && (raw_byte == DAC_MAGIC_HI)))
			dac = '0;
		else
			dac = {raw_byte, dac_lo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_PLAIN;
			pos_q    <= '0;
			asm_q    <= '0;
			dac_lo_q <= '0;
		end else begin
			if (cfg_wr_en)
				fmt_q <= cfg_wr_data;
			if (accept && fmt_ok) begin
				pos_q <= pos_nxt;
				if (in_body)
					asm_q <= nxt;
				else if (restart)
					asm_q <= '0;
				if (is_dac_lo)
					dac_lo_q <= raw_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
		end else if (adv) begin
			beat_s1.valid <= accept & fmt_ok & ((in_body & last) | is_dac_hi);
			beat_s1.index <= in_body ? idx : IDX_TRAILER;
			beat_s1.words <= in_body ? nxt : '0;
			beat_s1.dac   <= in_body ? '0 : dac;
		end
	end

endmodule

### rtl/core/rbdg_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbdg_decode
// Gray-decodes completed words below IDX_GRAY_END, derives roll position, mismatch and
// timestamps, and holds the result register of the output channel.
// ----------------------------------------------------------------------------
module rbdg_decode
	import rbdg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  beat_t   beat_s1,
	output logic    res_valid_q,
	output result_t res_q
);

	logic [11:0]          ts_hi_q [NumChips];
	result_t              res_nxt;
	logic [12:0]          mask0;
	logic                 mismatch;
	logic [3:0]           top1;
	logic                 at_roll;
	logic                 at_ts_lo;

	always_comb begin
		mask0    = beat_s1.words[0][12:0];
		mismatch = 1'b0;
		for (int k = 1; k < NumChips; k++)
			if (beat_s1.words[k][12:0] != mask0)
				mismatch = 1'b1;
		top1 = '0;
		for (int b = 0; b < 13; b++)
			if (mask0[b])
				top1 = 4'(b + 1);
		if (mask0[12] && mask0[11])
			top1 = 4'd0;
		else if (mask0[12] && (mask0[11:1] == '0) && mask0[0])
			top1 = 4'd1;
		at_roll  = (beat_s1.index == IDX_ROLL);
		at_ts_lo = (beat_s1.index == IDX_TS_LO);

		res_nxt.index         = beat_s1.index;
		res_nxt.dac           = beat_s1.dac;
		res_nxt.roll_pos      = (at_roll && !mismatch) ? top1 : '0;
		res_nxt.roll_mismatch = at_roll & mismatch;
		for (int k = 0; k < NumChips; k++) begin
			if (beat_s1.index < IDX_GRAY_END)
				res_nxt.words[k] = {beat_s1.words[k][15], 3'b000,
				                    gray12(beat_s1.words[k][11:0])};
			else
				res_nxt.words[k] = beat_s1.words[k];
			res_nxt.stamps[k] = at_ts_lo ?
				{ts_hi_q[k], gray12(beat_s1.words[k][12:1])} : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			for (int k = 0; k < NumChips; k++)
				ts_hi_q[k] <= '0;
		end else if (adv) begin
			res_valid_q <= beat_s1.valid;
			if (beat_s1.valid && (beat_s1.index == IDX_TS_HI))
				for (int k = 0; k < NumChips; k++)
					ts_hi_q[k] <= gray12(beat_s1.words[k][11:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_nxt;
	end

endmodule

### rtl/core/readout_bitplane_deinterleave_gray.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// readout_bitplane_deinterleave_gray
// Rebuilds four chip words from a raw bit-plane byte stream and emits them
// Gray-decoded, with roll, timestamp and injection DAC trailer results.
// ----------------------------------------------------------------------------
// Path: a byte that completes a word or the trailer passes through the assembly
// register, then the result register, before its result is valid.
// Throughput: one byte per cycle; the two registers advance together and
// stall only while the result register holds a beat not yet taken.
// Reset: arst_n clears position, assembly words, timestamps and valids;
// the format register comes up as 1.
// ----------------------------------------------------------------------------
module readout_bitplane_deinterleave_gray
	import rbdg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	rbdg_in_if.sink    byte_in,
	rbdg_out_if.source word_out
);

	logic    adv;
	beat_t   beat_s1;
	logic    res_valid_q;
	result_t res_q;

	assign adv           = !res_valid_q || word_out.ready;
	assign byte_in.ready = adv;

	rbdg_assemble u_assemble (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.adv         (adv),
		.in_valid    (byte_in.valid),
		.raw_byte    (byte_in.raw_byte),
		.event_start (byte_in.event_start),
		.beat_s1     (beat_s1)
	);

	rbdg_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.beat_s1     (beat_s1),
		.res_valid_q (res_valid_q),
		.res_q       (res_q)
	);

	assign word_out.valid           = res_valid_q;
	assign word_out.word_index      = res_q.index;
	assign word_out.word_chip0      = res_q.words[0];
	assign word_out.word_chip1      = res_q.words[1];
	assign word_out.word_chip2      = res_q.words[2];
	assign word_out.word_chip3      = res_q.words[3];
	assign word_out.roll_pos        = res_q.roll_pos;
	assign word_out.roll_mismatch   = res_q.roll_mismatch;
	assign word_out.timestamp_chip0 = res_q.stamps[0];
	assign word_out.timestamp_chip1 = res_q.stamps[1];
	assign word_out.timestamp_chip2 = res_q.stamps[2];
	assign word_out.timestamp_chip3 = res_q.stamps[3];
	assign word_out.injection_dac   = res_q.dac;

endmodule
